[sv/scms_pkg.sv]
// scms_pkg: shared types, constants and controller commands for the sparse column matrix store
// no dependencies
package scms_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int CAPACITY = 1024;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PTR_ADDR_W = $clog2(MAX_COLS + 1);
    localparam int LIM_W = 9;
    localparam int VAL_W = 32;
    localparam int ENTRY_W = ROW_W + VAL_W;

    localparam logic [0:0] REQ_READ = 1'b0;
    localparam logic [0:0] REQ_WRITE = 1'b1;

    localparam logic [0:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [0:0] CFG_NUM_COLS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [0:0] req_type;
        logic [7:0] row;
        logic [7:0] col;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] old_value;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_PTR_LO,
        S_PTR_HI,
        S_PTR_WAIT,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PUT,
        S_PTR_FIX,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic ptr_rd_lo;
        logic ptr_rd_hi;
        logic cap_lo;
        logic cap_hi;
        logic ent_rd;
        logic cap_ent;
        logic step_p;
        logic prep_shift;
        logic shift_up;
        logic shift_dn;
        logic put;
        logic ptr_fix_inc;
        logic ptr_fix_dec;
        logic cnt_inc;
        logic cnt_dec;
        logic clr_step;
        logic set_resp;
        logic [1:0] resp_status;
        logic resp_zero;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_of_range;
        logic is_write;
        logic val_zero;
        logic scan_done;
        logic found;
        logic full;
        logic refused;
        logic shift_done;
        logic fix_done;
        logic clr_done;
    } sts_t;

endpackage

[sv/sparse_column_matrix_store.sv]
// sparse_column_matrix_store: sparse matrix in compressed-sparse-column form
// depends on scms_pkg, scms_ctrl, scms_dp, scms_ram
//
// usage: one request at a time on s_valid/s_ready carrying req_t (read or write
// of one element); one response per request on m_valid/m_ready carrying rsp_t
// (old value and status). num_rows/num_cols are set through cfg_we/cfg_index/
// cfg_data while no request is in flight.
// sequence: a taken request passes S_PTR_LO, S_PTR_HI, S_PTR_WAIT, then one
// S_SEARCH/S_SEARCH_WAIT pair per column entry looked at (those below the row
// and the first one not below), then S_DECIDE and S_RESP; an insert or delete
// also shifts the tail of the entry memory (up to 1023 entries), then rewrites
// each column pointer after the column (up to 256). an out-of-range request
// goes from S_PTR_LO straight to S_RESP. s_ready rises with m_valid: the edge
// that loads the response register also returns the sequencer to idle. after
// reset the column pointer memory (257 entries) is cleared, during which s_ready
// stays low. a stalled receiver holds the response register; the next request is
// still taken and worked on, then waits until the held response is taken before its own is loaded.
module sparse_column_matrix_store import scms_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [LIM_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_data
);

    cmd_t cmd;
    sts_t sts;

    scms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    scms_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

[sv/scms_ram.sv]
// scms_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
module scms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/scms_ctrl.sv]
// scms_ctrl: request sequencer for the sparse column matrix store
// depends on scms_pkg
module scms_ctrl import scms_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic m_ready,
    input  logic m_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
            S_IDLE: if (s_valid) state_next = S_PTR_LO;
            S_PTR_LO: state_next = sts.out_of_range ? S_RESP : S_PTR_HI;
            S_PTR_HI: state_next = S_PTR_WAIT;
            S_PTR_WAIT: state_next = S_SEARCH;
            S_SEARCH: state_next = sts.scan_done ? S_DECIDE : S_SEARCH_WAIT;
            S_SEARCH_WAIT: state_next = S_SEARCH;
            S_DECIDE: begin
                if (!sts.is_write) begin
                    state_next = S_RESP;
                end else if (!sts.val_zero) begin
                    if (sts.found) state_next = S_PUT;
                    else if (sts.full) state_next = S_RESP;
                    else state_next = S_SHIFT_UP;
                end else begin
                    state_next = sts.found ? S_SHIFT_DN : S_RESP;
                end
            end
            S_SHIFT_UP: if (sts.shift_done) state_next = S_PUT;
            S_SHIFT_DN: if (sts.shift_done) state_next = S_PTR_FIX;
            S_PUT: state_next = sts.found ? S_RESP : S_PTR_FIX;
            S_PTR_FIX: if (sts.fix_done) state_next = S_RESP;
            S_RESP: if (!m_valid || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.load_req = s_valid;
            end
            S_PTR_LO: cmd.ptr_rd_lo = 1'b1;
            S_PTR_HI: begin
                cmd.ptr_rd_hi = 1'b1;
                cmd.cap_lo = 1'b1;
            end
            S_PTR_WAIT: cmd.cap_hi = 1'b1;
            S_SEARCH: begin
                cmd.ent_rd = 1'b1;
            end
            S_SEARCH_WAIT: begin
                cmd.cap_ent = 1'b1;
                cmd.step_p = 1'b1;
            end
            S_DECIDE: cmd.prep_shift = 1'b1;
            S_SHIFT_UP: cmd.shift_up = 1'b1;
            S_SHIFT_DN: begin
                cmd.shift_dn = 1'b1;
                cmd.cnt_dec = sts.shift_done;
            end
            S_PUT: begin
                cmd.put = 1'b1;
                cmd.cnt_inc = !sts.found;
            end
            S_PTR_FIX: begin
                cmd.ptr_fix_inc = sts.val_zero ? 1'b0 : 1'b1;
                cmd.ptr_fix_dec = sts.val_zero;
            end
            S_RESP: begin
                if (!m_valid || m_ready) begin
                    cmd.set_resp = 1'b1;
                    if (sts.out_of_range) begin
                        cmd.resp_status = ST_RANGE;
                        cmd.resp_zero = 1'b1;
                    end else if (sts.refused) begin
                        cmd.resp_status = ST_FULL;
                        cmd.resp_zero = 1'b1;
                    end else begin
                        cmd.resp_status = ST_OK;
                        cmd.resp_zero = !sts.found;
                    end
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

[sv/scms_dp.sv]
// scms_dp: pointer table, packed entry memory, counters and result register
// depends on scms_pkg and scms_ram
module scms_dp import scms_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [LIM_W-1:0]       cfg_data,
    input  req_t                   s_data,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   m_ready,
    output logic                   m_valid,
    output rsp_t                   m_data
);

    logic [LIM_W-1:0] rows_reg, cols_reg;
    req_t req_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] lo_reg, hi_reg, p_reg, k_reg;
    logic [PTR_ADDR_W-1:0] fix_reg;
    logic found_reg, done_reg, refused_reg;
    logic [VAL_W-1:0] old_reg;
    logic m_valid_reg;
    rsp_t rsp_reg;

    // pointer ram
    logic ptr_we;
    logic [PTR_ADDR_W-1:0] ptr_waddr, ptr_raddr;
    logic [CNT_W-1:0] ptr_wdata, ptr_rdata;

    // entry ram
    logic ent_we;
    logic [ADDR_W-1:0] ent_waddr, ent_raddr;
    logic [ENTRY_W-1:0] ent_wdata, ent_rdata;

    logic [ROW_W-1:0] ent_row;
    logic oor;
    logic [CNT_W-1:0] hi_clip;
    logic fix_last;
    logic fix_end;
    logic shift_busy;
    logic shift_end;

    assign ent_row = ent_rdata[ENTRY_W-1 -: ROW_W];
    assign oor = ({1'b0, req_reg.row} >= rows_reg) || ({1'b0, req_reg.col} >= cols_reg);
    assign hi_clip = (ptr_rdata > cnt_reg) ? cnt_reg : ptr_rdata;
    assign fix_last = (fix_reg == PTR_ADDR_W'(MAX_COLS));
    // fix pass is over once the last pointer has been written back
    assign fix_end = (fix_reg == PTR_ADDR_W'(MAX_COLS + 1));
    assign shift_busy = cmd.shift_up || cmd.shift_dn;

    // a shift needs its first read to land before writes begin
    assign shift_end = cmd.shift_up ? (done_reg && (k_reg <= p_reg))
                                    : (done_reg && (k_reg + 1'b1 >= cnt_reg));

    scms_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLS + 1)) u_ptr (
        .aclk  (aclk),
        .we    (ptr_we),
        .waddr (ptr_waddr),
        .wdata (ptr_wdata),
        .raddr (ptr_raddr),
        .rdata (ptr_rdata)
    );

    scms_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ent (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // pointer ram access; fix pass reads one ahead and writes back adjusted
    always_comb begin
        ptr_raddr = PTR_ADDR_W'(req_reg.col);
        if (cmd.ptr_rd_hi) ptr_raddr = PTR_ADDR_W'(req_reg.col) + 1'b1;
        if ((cmd.ptr_fix_inc || cmd.ptr_fix_dec) && !fix_end) ptr_raddr = fix_reg;
        ptr_we = 1'b0;
        ptr_waddr = fix_reg;
        ptr_wdata = '0;
        if (cmd.clr_step) begin
            ptr_we = 1'b1;
        end else if ((cmd.ptr_fix_inc || cmd.ptr_fix_dec) && done_reg) begin
            ptr_we = 1'b1;
            ptr_waddr = fix_reg - 1'b1;
            ptr_wdata = cmd.ptr_fix_inc ? ptr_rdata + 1'b1 : ptr_rdata - 1'b1;
        end
    end

    // entry ram access: shift up walks k from count down to p, shift down from p up
    always_comb begin
        ent_raddr = p_reg[ADDR_W-1:0];
        ent_we = 1'b0;
        ent_waddr = k_reg[ADDR_W-1:0];
        ent_wdata = ent_rdata;
        if (cmd.shift_up) begin
            ent_raddr = done_reg ? ADDR_W'(k_reg - 2'd2) : ADDR_W'(k_reg - 1'b1);
            ent_we = done_reg && (k_reg > p_reg);
        end else if (cmd.shift_dn) begin
            ent_raddr = done_reg ? ADDR_W'(k_reg + 2'd2) : ADDR_W'(k_reg + 1'b1);
            ent_we = done_reg && (k_reg + 1'b1 < cnt_reg);
        end else if (cmd.put) begin
            ent_we = 1'b1;
            ent_waddr = p_reg[ADDR_W-1:0];
            ent_wdata = {req_reg.row, req_reg.value};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= LIM_W'(MAX_ROWS);
            cols_reg <= LIM_W'(MAX_COLS);
            cnt_reg <= '0;
            fix_reg <= '0;
            m_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_NUM_ROWS) rows_reg <= cfg_data;
                if (cfg_index == CFG_NUM_COLS) cols_reg <= cfg_data;
            end
            if (cmd.set_resp) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (cmd.cnt_inc) cnt_reg <= cnt_reg + 1'b1;
            else if (cmd.cnt_dec) cnt_reg <= cnt_reg - 1'b1;

            if (cmd.clr_step || cmd.ptr_fix_inc || cmd.ptr_fix_dec) begin
                fix_reg <= fix_reg + 1'b1;
            end else if (cmd.cap_hi) begin
                fix_reg <= PTR_ADDR_W'(req_reg.col) + 1'b1;
            end

            // done flag: scan hit, shift primed, fix primed
            if (cmd.load_req || cmd.prep_shift || (shift_busy && shift_end)) begin
                done_reg <= 1'b0;
            end else if (cmd.cap_ent) begin
                // first row not below target ends the scan
                if (ent_row >= req_reg.row) done_reg <= 1'b1;
            end else if (shift_busy || cmd.ptr_fix_inc || cmd.ptr_fix_dec) begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_data;
            found_reg <= 1'b0;
            old_reg <= '0;
            refused_reg <= 1'b0;
        end
        if (cmd.cap_ent && (ent_row >= req_reg.row)) begin
            found_reg <= (ent_row == req_reg.row);
            old_reg <= ent_rdata[VAL_W-1:0];
        end
        if (cmd.cap_lo) lo_reg <= ptr_rdata;
        if (cmd.cap_hi) begin
            hi_reg <= hi_clip;
            p_reg <= lo_reg;
        end
        if (cmd.step_p && !(ent_row >= req_reg.row)) p_reg <= p_reg + 1'b1;
        if (cmd.prep_shift) begin
            k_reg <= found_reg ? p_reg : cnt_reg;
            refused_reg <= sts.is_write && !sts.val_zero && !found_reg && sts.full;
        end else if (cmd.shift_up && done_reg) begin
            k_reg <= k_reg - 1'b1;
        end else if (cmd.shift_dn && done_reg) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.set_resp) begin
            rsp_reg.status <= cmd.resp_status;
            rsp_reg.old_value <= cmd.resp_zero ? '0 : old_reg;
        end
    end

    always_comb begin
        sts.out_of_range = oor;
        sts.is_write = (req_reg.req_type == REQ_WRITE);
        sts.val_zero = (req_reg.value == '0);
        sts.scan_done = done_reg || (p_reg >= hi_reg);
        sts.found = found_reg;
        sts.full = (cnt_reg >= CNT_W'(CAPACITY));
        sts.refused = refused_reg;
        sts.shift_done = shift_end;
        sts.fix_done = done_reg && fix_end;
        sts.clr_done = fix_last;
    end

    assign m_valid = m_valid_reg;
    assign m_data = rsp_reg;

endmodule

[tb/sparse_column_matrix_store_tb.sv]
// sparse_column_matrix_store_tb: self-checking regression for the sparse column matrix store
// depends on scms_pkg and sparse_column_matrix_store; keeps its own copy of the matrix
`timescale 1ns / 1ps

module sparse_column_matrix_store_tb;
    import scms_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [LIM_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    req_t             s_data;
    logic             m_valid;
    logic             m_ready;
    rsp_t             m_data;

    sparse_column_matrix_store u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // matrix copy: dense view plus stored-entry count
    logic [31:0]      cell_val [0:MAX_COLS-1][0:MAX_ROWS-1];
    bit               cell_used [0:MAX_COLS-1][0:MAX_ROWS-1];
    int               stored_count;
    logic [LIM_W-1:0] rows_in_use;
    logic [LIM_W-1:0] cols_in_use;

    rsp_t   expected_rsp_q[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;
    int     sent_count;
    int     got_count;
    int     full_hits;
    int     range_hits;

    function automatic rsp_t matrix_apply(req_t rq);
        rsp_t rs;
        int   lr;
        int   lc;
        lr = (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
        lc = (cols_in_use > MAX_COLS) ? MAX_COLS : cols_in_use;
        rs.old_value = '0;
        rs.status = ST_OK;
        if (rq.row >= lr || rq.col >= lc) begin
            rs.status = ST_RANGE;
            range_hits++;
            return rs;
        end
        if (cell_used[rq.col][rq.row])
            rs.old_value = cell_val[rq.col][rq.row];
        if (rq.req_type == REQ_WRITE) begin
            if (rq.value != 0) begin
                if (!cell_used[rq.col][rq.row]) begin
                    if (stored_count >= CAPACITY) begin
                        rs.status = ST_FULL;
                        rs.old_value = '0;
                        full_hits++;
                        return rs;
                    end
                    stored_count++;
                    cell_used[rq.col][rq.row] = 1'b1;
                end
                cell_val[rq.col][rq.row] = rq.value;
            end else if (cell_used[rq.col][rq.row]) begin
                cell_used[rq.col][rq.row] = 1'b0;
                stored_count--;
            end
        end
        return rs;
    endfunction

    // valid stays up between back-to-back requests and drops only while idling
    task automatic send_request(input logic [0:0] kind, input int r, input int c,
                                input logic [31:0] v);
        req_t rq;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        rq.req_type = kind;
        rq.row = r[7:0];
        rq.col = c[7:0];
        rq.value = v;
        s_valid <= 1'b1;
        s_data <= rq;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_rsp_q.push_back(matrix_apply(rq));
        sent_count++;
    endtask

    task automatic drain_and_wait();
        s_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [0:0] idx, input int v);
        drain_and_wait();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[LIM_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_NUM_ROWS)
            rows_in_use = v[LIM_W-1:0];
        else
            cols_in_use = v[LIM_W-1:0];
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // response checker
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            got_count++;
            if (expected_rsp_q.size() == 0) begin
                $display("%0t: unexpected response old_value=%h status=%0d",
                         $time, m_data.old_value, m_data.status);
                errors++;
            end else begin
                want = expected_rsp_q.pop_front();
                if (m_data.old_value !== want.old_value) begin
                    $display("%0t: old_value mismatch expected %h actual %h",
                             $time, want.old_value, m_data.old_value);
                    errors++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed_edges();
        send_request(REQ_READ, 0, 0, 32'd0);
        send_request(REQ_WRITE, 0, 0, 32'h8000_0000);
        send_request(REQ_WRITE, 255, 255, 32'h7fff_ffff);
        send_request(REQ_WRITE, 128, 0, 32'hffff_ffff);
        send_request(REQ_WRITE, 5, 0, 32'd1);
        send_request(REQ_READ, 128, 0, 32'd0);
        send_request(REQ_WRITE, 128, 0, 32'h1234_5678);
        send_request(REQ_WRITE, 0, 0, 32'd0);
        send_request(REQ_WRITE, 0, 0, 32'd0);
        send_request(REQ_READ, 255, 255, 32'hdead_beef);
        send_request(REQ_WRITE, 3, 100, 32'h5555_aaaa);
        send_request(REQ_READ, 3, 100, 32'd0);
        send_request(REQ_WRITE, 5, 0, 32'd0);
        send_request(REQ_READ, 5, 0, 32'd0);
    endtask

    task automatic test_range_limits();
        write_limit(CFG_NUM_ROWS, 1);
        write_limit(CFG_NUM_COLS, 1);
        send_request(REQ_READ, 0, 0, 32'd0);
        send_request(REQ_WRITE, 1, 0, 32'd7);
        send_request(REQ_WRITE, 0, 1, 32'd7);
        send_request(REQ_READ, 255, 255, 32'd0);
        write_limit(CFG_NUM_ROWS, 0);
        send_request(REQ_READ, 0, 0, 32'd0);
        // entries beyond the bounds stay stored
        write_limit(CFG_NUM_ROWS, 16);
        write_limit(CFG_NUM_COLS, 8);
        for (int i = 0; i < 60; i++)
            send_request(1'($urandom_range(1)), $urandom_range(20), $urandom_range(11),
                         ($urandom_range(3) == 0) ? 32'd0 : random_value());
        write_limit(CFG_NUM_ROWS, 256);
        write_limit(CFG_NUM_COLS, 256);
        send_request(REQ_READ, 255, 255, 32'd0);
    endtask

    task automatic test_random_traffic(input int n, input int rmax, input int cmax);
        for (int i = 0; i < n; i++) begin
            logic [0:0] k;
            k = ($urandom_range(2) == 0) ? REQ_READ : REQ_WRITE;
            send_request(k, $urandom_range(rmax), $urandom_range(cmax),
                         ($urandom_range(4) == 0) ? 32'd0 : random_value());
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        test_random_traffic(8, 255, 255);
        // sender pauses until everything is back
        drain_and_wait();
        test_random_traffic(8, 255, 255);
    endtask

    task automatic test_dense_columns();
        // pack many entries into a few low columns for long shifts, then thin them out
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 100; i++)
            send_request(REQ_WRITE, $urandom_range(255), $urandom_range(3),
                         (i >= 70 && $urandom_range(1) == 0) ? 32'd0
                                                             : (random_value() | 32'd1));
    endtask

    initial begin
        errors = 0;
        hold_cycles = 0;
        sent_count = 0;
        got_count = 0;
        full_hits = 0;
        range_hits = 0;
        stored_count = 0;
        rows_in_use = 256;
        cols_in_use = 256;
        send_idle_pct = 19;
        recv_idle_pct = 85;
        for (int c = 0; c < MAX_COLS; c++)
            for (int r = 0; r < MAX_ROWS; r++) begin
                cell_used[c][r] = 1'b0;
                cell_val[c][r] = '0;
            end
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_NUM_ROWS;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_edges();
        test_range_limits();
        test_random_traffic(120, 15, 15);
        send_idle_pct = 85;
        recv_idle_pct = 19;
        test_random_traffic(120, 31, 7);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(140, 255, 255);
        test_dense_columns();
        drain_and_wait();
        repeat (1500) @(posedge aclk);
        $display("covered %0d requests, %0d responses, %0d out-of-range, %0d store-full",
                 sent_count, got_count, range_hits, full_hits);
        $display("limits swept from zero to 256, long shifts in packed columns, "
                 , "long receiver stall and drain pause done");
        if (errors == 0 && expected_rsp_q.size() == 0)
            $display("sparse_column_matrix_store regression: pass");
        else
            $display("sparse_column_matrix_store regression: fail");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("sparse_column_matrix_store regression: fail");
        $finish;
    end

endmodule

[sim.f]
sv/scms_pkg.sv
sv/scms_ram.sv
sv/scms_ctrl.sv
sv/scms_dp.sv
sv/sparse_column_matrix_store.sv
tb/sparse_column_matrix_store_tb.sv
